>>> hw/rtl/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants of the nearest-centre classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

  // Input command codes.
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // Fixed field widths of the external interface.
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned DIST_OUT_W = 33;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write the incoming point into the centre table
    logic capture;  // latch the incoming point for a search
    logic issue;    // read one table slot into the pipeline
    logic first;    // the issued slot is the first of the search
    logic last;     // the issued slot is the last of the search
  } ncc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;     // the search result is presented this cycle
  } ncc_status_t;

endpackage

>>> hw/rtl/ncc_ctrl.sv
// ----------------------------------------------------------------------------
// ncc_ctrl
// Sequencer of the classifier: holds the slot count register and walks the
// slot index over the table for each classify item.
// ----------------------------------------------------------------------------
module ncc_ctrl import ncc_pkg::*; #(
  parameter int unsigned MAX_CENTRES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           command_i,
  input  logic                           cfg_we_i,
  input  logic [CFG_W-1:0]               cfg_wdata_i,
  input  ncc_status_t                    status_i,
  output ncc_cmd_t                       cmd_o,
  output logic [$clog2(MAX_CENTRES)-1:0] rd_idx_o,
  output logic                           busy_o
);

  localparam int unsigned IDX_W = $clog2(MAX_CENTRES);
  localparam int unsigned CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } ctrl_state_e;

  ctrl_state_e      state_q, state_d;
  logic [CFG_W-1:0] num_q;
  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [IDX_W-1:0] last_idx;
  logic [CMP_W-1:0] num_ext;

  // Zero counts as one slot; counts above the table depth saturate.
  assign num_ext = CMP_W'(num_q);
  always_comb begin
    if (num_q == '0) begin
      last_idx = '0;
    end else if (num_ext >= CMP_W'(MAX_CENTRES)) begin
      last_idx = IDX_W'(MAX_CENTRES - 1);
    end else begin
      last_idx = IDX_W'(num_ext - CMP_W'(1));
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (command_i == CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            k_d           = '0;
            last_d        = last_idx;
            state_d       = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        cmd_o.first = (k_q == '0);
        cmd_o.last  = (k_q == last_q);
        if (k_q == last_q) begin
          state_d = S_WAIT;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (status_i.done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      num_q   <= CFG_W'(1);
      k_q     <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
    end
  end

  assign rd_idx_o = k_q;
  assign busy_o   = (state_q != S_IDLE);

endmodule

>>> hw/rtl/ncc_datapath.sv
// ----------------------------------------------------------------------------
// ncc_datapath
// Centre table memory and the distance pipeline: read, difference, square,
// then sum and compare against the running best.
// ----------------------------------------------------------------------------
module ncc_datapath import ncc_pkg::*; #(
  parameter int unsigned MAX_CENTRES = 32,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ncc_cmd_t                       cmd_i,
  input  logic [$clog2(MAX_CENTRES)-1:0] rd_idx_i,
  input  logic [SLOT_W-1:0]              slot_i,
  input  logic signed [COORD_BITS-1:0]   coord_x_i,
  input  logic signed [COORD_BITS-1:0]   coord_y_i,
  output ncc_status_t                    status_o,
  output logic [SLOT_W-1:0]              nearest_slot_o,
  output logic [DIST_OUT_W-1:0]          distance_sq_o
);

  localparam int unsigned IDX_W = $clog2(MAX_CENTRES);
  localparam int unsigned CMP_W = (IDX_W + 1 > SLOT_W) ? IDX_W + 1 : SLOT_W;
  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = SQ_W + 1;

  logic signed [COORD_BITS-1:0] mem_x [MAX_CENTRES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_CENTRES];

  logic signed [COORD_BITS-1:0] pt_x_q, pt_y_q;

  // Stage 1: table read.
  logic                         v1_q, f1_q, l1_q;
  logic [IDX_W-1:0]             idx1_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  // Stage 2: absolute differences.
  logic                         v2_q, f2_q, l2_q;
  logic [IDX_W-1:0]             idx2_q;
  logic [COORD_BITS-1:0]        mx_q, my_q;
  // Stage 3: squares.
  logic                         v3_q, f3_q, l3_q;
  logic [IDX_W-1:0]             idx3_q;
  logic [SQ_W-1:0]              sqx_q, sqy_q;
  // Stage 4: running best.
  logic [SUM_W-1:0]             best_q;
  logic [IDX_W-1:0]             best_idx_q;
  logic                         done_q;

  logic                         wr_ok;
  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS:0]          ax, ay;
  logic [SUM_W-1:0]             sum;

  // Loads to slots beyond the table are dropped.
  assign wr_ok = cmd_i.load && (CMP_W'(slot_i) < CMP_W'(MAX_CENTRES));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_x[IDX_W'(slot_i)] <= coord_x_i;
      mem_y[IDX_W'(slot_i)] <= coord_y_i;
    end
    cx_q <= mem_x[rd_idx_i];
    cy_q <= mem_y[rd_idx_i];
  end

  assign dx = (COORD_BITS+1)'(cx_q) - (COORD_BITS+1)'(pt_x_q);
  assign dy = (COORD_BITS+1)'(cy_q) - (COORD_BITS+1)'(pt_y_q);
  assign ax = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
  assign ay = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
  assign sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pt_x_q <= coord_x_i;
      pt_y_q <= coord_y_i;
    end
    idx1_q <= rd_idx_i;
    idx2_q <= idx1_q;
    mx_q   <= ax[COORD_BITS-1:0];
    my_q   <= ay[COORD_BITS-1:0];
    idx3_q <= idx2_q;
    sqx_q  <= SQ_W'(mx_q) * SQ_W'(mx_q);
    sqy_q  <= SQ_W'(my_q) * SQ_W'(my_q);
    // Later slots win ties.
    if (v3_q && (f3_q || (sum <= best_q))) begin
      best_q     <= sum;
      best_idx_q <= idx3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      f1_q   <= 1'b0;
      l1_q   <= 1'b0;
      v2_q   <= 1'b0;
      f2_q   <= 1'b0;
      l2_q   <= 1'b0;
      v3_q   <= 1'b0;
      f3_q   <= 1'b0;
      l3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= cmd_i.issue;
      f1_q   <= cmd_i.first;
      l1_q   <= cmd_i.last;
      v2_q   <= v1_q;
      f2_q   <= f1_q;
      l2_q   <= l1_q;
      v3_q   <= v2_q;
      f3_q   <= f2_q;
      l3_q   <= l2_q;
      done_q <= v3_q && l3_q;
    end
  end

  assign status_o.done  = done_q;
  assign nearest_slot_o = SLOT_W'(best_idx_q);
  assign distance_sq_o  = DIST_OUT_W'(best_q);

endmodule

>>> hw/rtl/nearest_centre_classifier.sv
// ----------------------------------------------------------------------------
// nearest_centre_classifier
// Finds the nearest of a loaded table of centre points for each classify
// command and reports its slot and squared Euclidean distance.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Handshake               Payload
// command    in         start_i / busy_o        command_i, slot_i, coord_x_i, coord_y_i
// result     out        done_o (one-cycle)      nearest_slot_o, distance_sq_o
// config     in         cfg_we_i                cfg_wdata_i (slot count)
//
// A transfer on the command channel happens at a rising edge with start_i
// high and busy_o low. A load command writes the table at that edge and
// leaves the block idle, so the next command can follow in the next cycle.
// A classify command raises busy_o until its result is out: the controller
// issues one table read per cycle for each of the N slots searched, and the
// datapath then reads, takes differences, squares and compares before the
// result appears. done_o is high for exactly one cycle with the result,
// in the last busy cycle; busy_o drops at the edge that ends it, so the next
// command can transfer in the following cycle. The receiver cannot stall the result.
// Reset (rst_ni low) returns the controller to idle and sets the slot count
// to one; the centre table is not cleared and must be loaded before use.
//
module nearest_centre_classifier import ncc_pkg::*; #(
  parameter int unsigned MAX_CENTRES = 32,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         command_i,
  input  logic [SLOT_W-1:0]            slot_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         done_o,
  output logic [SLOT_W-1:0]            nearest_slot_o,
  output logic [DIST_OUT_W-1:0]        distance_sq_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_CENTRES);

  ncc_cmd_t         cmd;
  ncc_status_t      status;
  logic [IDX_W-1:0] rd_idx;
  logic             busy;

  // The controller only reacts to start while idle, so gating start with
  // busy here keeps the transfer rule in one place.
  ncc_ctrl #(
    .MAX_CENTRES (MAX_CENTRES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i && !busy),
    .command_i   (command_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx),
    .busy_o      (busy)
  );

  // Table memory plus the four-stage distance and compare pipeline.
  ncc_datapath #(
    .MAX_CENTRES (MAX_CENTRES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_idx_i       (rd_idx),
    .slot_i         (slot_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .status_o       (status),
    .nearest_slot_o (nearest_slot_o),
    .distance_sq_o  (distance_sq_o)
  );

  assign busy_o = busy;
  assign done_o = status.done;

endmodule

>>> dv/tb_nearest_centre_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_centre_classifier
// Self-checking bench: loads centre tables, classifies points under many slot
// counts and checks each reported slot and squared distance against a typed-in
// value or a predictor that searches its own copy of the table.
// ----------------------------------------------------------------------------
module tb_nearest_centre_classifier;
  import ncc_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned ITEM_TARGET = 1500;
  // The last stretch of the run goes without any idle cycles.
  localparam int unsigned CALM_TAIL   = 200;

  // One expected classification result.
  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic [DIST_OUT_W-1:0] sq_dist;
  } nearest_t;

  // One row of the directed table. A row may first change the slot count,
  // and its result is either typed in or left to the predictor.
  typedef struct packed {
    logic                set_count;
    logic [CFG_W-1:0]    count;
    logic                cmd;
    logic [SLOT_W-1:0]   slot;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic                typed;
    nearest_t            want;
  } step_row_t;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     start_i     = 1'b0;
  logic                     command_i   = CMD_LOAD;
  logic [SLOT_W-1:0]        slot_i      = '0;
  logic signed [15:0]       coord_x_i   = '0;
  logic signed [15:0]       coord_y_i   = '0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [SLOT_W-1:0]        nearest_slot_o;
  logic [DIST_OUT_W-1:0]    distance_sq_o;

  // Predictor state: our own copy of the centre table and the slot count.
  logic signed [15:0]       centre_x [TABLE_DEPTH];
  logic signed [15:0]       centre_y [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   centre_loaded = '0;
  logic [CFG_W-1:0]         slot_count    = 6'd1;

  nearest_t                 pending_results [$];
  nearest_t                 oldest_result;
  step_row_t                directed_rows [$];
  int unsigned              items_sent     = 0;
  int unsigned              mismatch_count = 0;

  nearest_centre_classifier #(
    .MAX_CENTRES(32),
    .COORD_BITS (16)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .slot_i        (slot_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .done_o        (done_o),
    .nearest_slot_o(nearest_slot_o),
    .distance_sq_o (distance_sq_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // A count of zero still searches slot zero; counts above the table depth
  // saturate to the full table.
  function automatic int unsigned searched_slots();
    if (slot_count == 0) return 1;
    if (slot_count > TABLE_DEPTH) return TABLE_DEPTH;
    return slot_count;
  endfunction

  function automatic logic [DIST_OUT_W-1:0] square_gap(input logic signed [15:0] a,
                                                       input logic signed [15:0] b);
    longint gap;
    gap = longint'(a) - longint'(b);
    return DIST_OUT_W'(gap * gap);
  endfunction

  // Linear search with a less-or-equal compare, so the highest slot wins
  // among equally near centres.
  function automatic nearest_t find_nearest(input logic signed [15:0] x,
                                            input logic signed [15:0] y);
    nearest_t              best;
    logic [DIST_OUT_W-1:0] cand;
    for (int k = 0; k < searched_slots(); k++) begin
      cand = square_gap(centre_x[k], x) + square_gap(centre_y[k], y);
      if (k == 0 || cand <= best.sq_dist) begin
        best.sq_dist = cand;
        best.slot    = SLOT_W'(k);
      end
    end
    return best;
  endfunction

  function automatic void add_row(input logic set_count, input logic [CFG_W-1:0] count,
                                  input logic cmd, input logic [SLOT_W-1:0] slot,
                                  input logic signed [15:0] x, input logic signed [15:0] y,
                                  input logic typed, input logic [SLOT_W-1:0] want_slot,
                                  input logic [DIST_OUT_W-1:0] want_dist);
    step_row_t row;
    row.set_count    = set_count;
    row.count        = count;
    row.cmd          = cmd;
    row.slot         = slot;
    row.x            = x;
    row.y            = y;
    row.typed        = typed;
    row.want.slot    = want_slot;
    row.want.sq_dist = want_dist;
    directed_rows    = {directed_rows, row};
  endfunction

  // Coordinates by flavor: full range, a tiny grid that makes ties common,
  // or values at and next to the extremes and around zero.
  function automatic logic signed [15:0] random_coord(input int unsigned flavor);
    case (flavor)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 6))
          0: return -16'sd32768;
          1: return -16'sd32767;
          2: return -16'sd1;
          3: return 16'sd0;
          4: return 16'sd1;
          5: return 16'sd32766;
          default: return 16'sd32767;
        endcase
      end
    endcase
  endfunction

  // Presents one command and holds it until a transfer takes place, then
  // updates the predictor. Must be called right after a rising edge.
  task automatic transfer_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                               input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic typed, input nearest_t want);
    nearest_t predicted;
    start_i   <= 1'b1;
    command_i <= cmd;
    slot_i    <= slot;
    coord_x_i <= x;
    coord_y_i <= y;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (cmd == CMD_LOAD) begin
      centre_x[slot]      = x;
      centre_y[slot]      = y;
      centre_loaded[slot] = 1'b1;
    end else begin
      predicted       = typed ? want : find_nearest(x, y);
      pending_results = {pending_results, predicted};
    end
    items_sent++;
  endtask

  // A random idle burst on the command side, with junk on the payload.
  task automatic maybe_idle(input bit calm);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      start_i   <= 1'b0;
      command_i <= 1'($urandom);
      slot_i    <= SLOT_W'($urandom);
      coord_x_i <= 16'($urandom);
      coord_y_i <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The count register is only written with the block idle: every result in
  // and a short pause so that a trailing load has surely settled.
  task automatic write_count(input logic [CFG_W-1:0] value);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    slot_count   = value;
  endtask

  // Random traffic is mostly loads and classifications of points close to,
  // on top of, or far from the loaded centres. A classification that would
  // read a never-loaded slot is turned into a load of the lowest such slot,
  // which also fills the table whenever the count grows.
  task automatic random_item(input bit calm);
    logic               cmd;
    logic [SLOT_W-1:0]  slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    int unsigned        flavor;
    int unsigned        src;
    int unsigned        need;
    nearest_t           unused;
    flavor = $urandom_range(0, 2);
    cmd    = ($urandom_range(0, 9) < 4) ? CMD_LOAD : CMD_CLASSIFY;
    slot   = SLOT_W'($urandom);
    x      = random_coord(flavor);
    y      = random_coord(flavor);
    need   = searched_slots();
    unused = '0;
    if (cmd == CMD_CLASSIFY) begin
      for (int k = need - 1; k >= 0; k--) begin
        if (!centre_loaded[k]) begin
          cmd  = CMD_LOAD;
          slot = SLOT_W'(k);
        end
      end
    end
    // Now and then reuse a centre exactly: duplicate centres give ties and
    // points on a centre give a zero distance.
    if ($urandom_range(0, 5) == 0) begin
      src = (cmd == CMD_LOAD) ? $urandom_range(0, TABLE_DEPTH - 1) : $urandom_range(0, need - 1);
      if (centre_loaded[src]) begin
        x = centre_x[src];
        y = centre_y[src];
      end
    end
    transfer_item(cmd, slot, x, y, 1'b0, unused);
    maybe_idle(calm);
  endtask

  // Results cannot be held off, so each done_o pulse is checked at the edge
  // that ends it against the oldest outstanding classification.
  always @(posedge clk_i) begin
    if (done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got slot %0d distance %0d",
                 $time, nearest_slot_o, distance_sq_o);
      end else begin
        oldest_result = pending_results.pop_front();
        if (nearest_slot_o !== oldest_result.slot) begin
          mismatch_count++;
          $display("%0t: nearest_slot mismatch, expected %0d, got %0d",
                   $time, oldest_result.slot, nearest_slot_o);
        end
        if (distance_sq_o !== oldest_result.sq_dist) begin
          mismatch_count++;
          $display("%0t: distance_sq mismatch, expected %0d, got %0d",
                   $time, oldest_result.sq_dist, distance_sq_o);
        end
      end
    end
  end

  initial begin
    int unsigned           phase;
    int unsigned           phase_items;
    logic [CFG_W-1:0]      next_count;
    logic [CFG_W-1:0]      opening_counts [6];

    opening_counts = '{6'd32, 6'd63, 6'd0, 6'd1, 6'd33, 6'd2};

    // Directed table. Typed results are the ones plain to see: one centre
    // with extreme coordinates and the slot count at its reset value or
    // at zero. The rest, including the ties, go through the predictor.
    add_row(1'b0, 6'd0, CMD_LOAD,     5'd0,  -16'sd32768, -16'sd32768, 1'b0, 5'd0, 33'd0);
    add_row(1'b0, 6'd0, CMD_CLASSIFY, 5'd31,  16'sd32767,  16'sd32767, 1'b1, 5'd0,
            33'd8589672450);
    add_row(1'b0, 6'd0, CMD_CLASSIFY, 5'd0,  -16'sd32768, -16'sd32768, 1'b1, 5'd0, 33'd0);
    add_row(1'b0, 6'd0, CMD_LOAD,     5'd1,   16'sd32767,  16'sd32767, 1'b0, 5'd0, 33'd0);
    // Still one slot searched after reset, so slot one is not seen.
    add_row(1'b0, 6'd0, CMD_CLASSIFY, 5'd0,   16'sd32767,  16'sd32767, 1'b1, 5'd0,
            33'd8589672450);
    // A count of zero behaves like one.
    add_row(1'b1, 6'd0, CMD_CLASSIFY, 5'd0,   16'sd0,      16'sd0,     1'b1, 5'd0,
            33'd2147483648);
    add_row(1'b1, 6'd2, CMD_CLASSIFY, 5'd0,   16'sd0,      16'sd0,     1'b0, 5'd0, 33'd0);
    // Opposite corners at the same distance: the later slot must win.
    add_row(1'b0, 6'd0, CMD_CLASSIFY, 5'd0,   16'sd32767, -16'sd32768, 1'b0, 5'd0, 33'd0);
    add_row(1'b0, 6'd0, CMD_LOAD,     5'd2,   16'sd32767,  16'sd32767, 1'b0, 5'd0, 33'd0);
    // Two identical centres tie for any point.
    add_row(1'b1, 6'd3, CMD_CLASSIFY, 5'd0,   16'sd100,   -16'sd5,     1'b0, 5'd0, 33'd0);
    add_row(1'b0, 6'd0, CMD_LOAD,     5'd2,  -16'sd1,      16'sd0,     1'b0, 5'd0, 33'd0);
    add_row(1'b0, 6'd0, CMD_CLASSIFY, 5'd0,   16'sd0,      16'sd0,     1'b0, 5'd0, 33'd0);
    add_row(1'b0, 6'd0, CMD_LOAD,     5'd31,  16'sd0,      16'sd0,     1'b0, 5'd0, 33'd0);
    add_row(1'b0, 6'd0, CMD_LOAD,     5'd3,   16'sd0,      16'sd0,     1'b0, 5'd0, 33'd0);
    add_row(1'b1, 6'd4, CMD_CLASSIFY, 5'd0,   16'sd0,      16'sd0,     1'b0, 5'd0, 33'd0);
    add_row(1'b0, 6'd0, CMD_CLASSIFY, 5'd0,  -16'sd32768,  16'sd32767, 1'b0, 5'd0, 33'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_count) write_count(directed_rows[i].count);
      transfer_item(directed_rows[i].cmd, directed_rows[i].slot, directed_rows[i].x,
                    directed_rows[i].y, directed_rows[i].typed, directed_rows[i].want);
      maybe_idle(1'b0);
    end

    // Random phases, each but the last under its own slot count. The count changes
    // only once everything outstanding has drained, so every phase boundary but
    // the last is also a point where the sender waits for all results to come back.
    // The last stretch runs as one phase so that it has no pauses at all.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent + CALM_TAIL < ITEM_TARGET) begin
        next_count = (phase < 6) ? opening_counts[phase] : CFG_W'($urandom_range(0, 63));
        write_count(next_count);
        phase_items = $urandom_range(60, 140);
      end else begin
        phase_items = ITEM_TARGET - items_sent;
      end
      repeat (phase_items) begin
        if (items_sent < ITEM_TARGET)
          random_item(items_sent + CALM_TAIL >= ITEM_TARGET);
      end
      phase++;
    end

    // Drain: a bounded wait for the last results and a short settle outlast
    // even the longest search.
    start_i <= 1'b0;
    for (int n = 0; n < 5000 && pending_results.size() != 0; n++) @(posedge clk_i);
    repeat (48) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      oldest_result = pending_results.pop_front();
      mismatch_count++;
      $display("%0t: missing result, expected slot %0d distance %0d, got none",
               $time, oldest_result.slot, oldest_result.sq_dist);
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_ctrl.sv
hw/rtl/ncc_datapath.sv
hw/rtl/nearest_centre_classifier.sv
dv/tb_nearest_centre_classifier.sv
